// File: sv/asg_pkg.sv
// ----------------------------------------------------------------------------
// asg_pkg
// shared widths, register indexes and controller/datapath command types
// ----------------------------------------------------------------------------
package asg_pkg;

    localparam int TEMP_W     = 15;
    localparam int VAL_W      = 16;
    localparam int OX_W       = 7;
    localparam int OY_W       = 6;
    localparam int H_W        = 6;
    localparam int DIFF_W     = 16;
    localparam int NUM_W      = DIFF_W + H_W;
    localparam int Q_W        = 6;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 8;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(Q_W);
    localparam logic [VAL_W-1:0]  MARGIN    = VAL_W'(10);
    localparam logic [H_W-1:0]    H_RESET   = H_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 2'd2;

    typedef struct packed {
        logic push;
        logic scan_upd;
        logic start_draw;
        logic div_load;
        logic div_step;
        logic emit;
    } asg_cmd_t;

    typedef struct packed {
        logic first_sample;
        logic scan_done;
        logic div_done;
        logic last;
        logic out_free;
    } asg_status_t;

endpackage

// File: sv/asg_in_if.sv
// ----------------------------------------------------------------------------
// asg_in_if
// sample request channel: valid, ready and the temperature payload
// ----------------------------------------------------------------------------
interface asg_in_if;
    import asg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

// File: sv/asg_out_if.sv
// ----------------------------------------------------------------------------
// asg_out_if
// span request channel: valid, ready and one column span
// ----------------------------------------------------------------------------
interface asg_out_if;
    import asg_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column_x;
    logic [COL_W-1:0] span_top;
    logic [COL_W-1:0] span_bottom;
    logic             last_column;

    modport source (output valid, output column_x, output span_top, output span_bottom,
                    output last_column, input ready);
    modport sink   (input valid, input column_x, input span_top, input span_bottom,
                    input last_column, output ready);
endinterface

// File: sv/asg_ram.sv
// ----------------------------------------------------------------------------
// asg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module asg_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/asg_ctrl.sv
// ----------------------------------------------------------------------------
// asg_ctrl
// sequencer: push, min/max scan, then per column divide and emit
// ----------------------------------------------------------------------------
module asg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  asg_pkg::asg_status_t status,
    output asg_pkg::asg_cmd_t    cmd
);
    import asg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_UPD = 7'b0000100,
        S_DRAW_RD  = 7'b0001000,
        S_DIV_LOAD = 7'b0010000,
        S_DIV_RUN  = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = status.first_sample ? S_IDLE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (status.scan_done)
                begin
                    cmd.start_draw = 1'b1;
                    state_next     = S_DRAW_RD;
                end
                else
                begin
                    state_next = S_SCAN_UPD;
                end
            end
            S_SCAN_UPD:
            begin
                cmd.scan_upd = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_DRAW_RD:
            begin
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last ? S_IDLE : S_DRAW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// File: sv/asg_datapath.sv
// ----------------------------------------------------------------------------
// asg_datapath
// history ring, config registers, min/max, row divider and span output stage
// ----------------------------------------------------------------------------
module asg_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  asg_pkg::asg_cmd_t                cmd,
    output asg_pkg::asg_status_t             status,
    input  logic signed [asg_pkg::TEMP_W-1:0] temperature,
    input  logic                             write_enable,
    input  logic [asg_pkg::CFG_IDX_W-1:0]    reg_index,
    input  logic [asg_pkg::CFG_DATA_W-1:0]   write_data,
    asg_out_if.source                        spans
);
    import asg_pkg::*;

    localparam int PTR_W = $clog2(WIDTH);
    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WIDTH - 1);
    localparam logic [COL_W-1:0] COL_BASE = COL_W'(WIDTH);

    logic [OX_W-1:0]         origin_x_reg;
    logic [OY_W-1:0]         origin_y_reg;
    logic [H_W-1:0]          height_reg;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic signed [VAL_W-1:0] hi_reg;
    logic signed [VAL_W-1:0] lo_reg;
    logic [DIFF_W-1:0]       den_reg;
    logic [DIFF_W-1:0]       rem_reg;
    logic [Q_W-1:0]          low_reg;
    logic [Q_W-1:0]          q_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [ROW_W-1:0]        prev_reg;

    logic                    out_valid_reg;
    logic [COL_W-1:0]        column_reg;
    logic [COL_W-1:0]        top_reg;
    logic [COL_W-1:0]        bottom_reg;
    logic                    last_reg;

    logic [PTR_W-1:0]        head_dec;
    logic [PTR_W-1:0]        ptr_inc;
    logic [TEMP_W-1:0]       rdata;
    logic signed [VAL_W-1:0] rval;
    logic signed [VAL_W-1:0] sample_ext;
    logic [DIFF_W:0]         den_sum;
    logic [DIFF_W:0]         diff;
    logic [NUM_W-1:0]        num;
    logic [DIFF_W:0]         trial;
    logic                    qbit;
    logic [ROW_W-1:0]        q_ceil;
    logic [ROW_W-1:0]        y;
    logic [ROW_W-1:0]        top;
    logic [ROW_W-1:0]        bottom;

    assign head_dec   = (head_reg == '0) ? LAST_PTR : head_reg - 1'b1;
    assign ptr_inc    = (ptr_reg == LAST_PTR) ? '0 : ptr_reg + 1'b1;
    assign rval       = VAL_W'(signed'(rdata));
    assign sample_ext = VAL_W'(temperature);

    asg_ram #(
        .DATA_W (TEMP_W),
        .DEPTH  (WIDTH)
    ) u_history (
        .clk    (clk),
        .we     (cmd.push),
        .waddr  (head_dec),
        .wdata  (temperature),
        .raddr  (ptr_reg),
        .rdata  (rdata)
    );

    // scale setup and row arithmetic
    assign den_sum = (DIFF_W + 1)'({hi_reg[VAL_W-1], hi_reg} - {lo_reg[VAL_W-1], lo_reg})
                   + (DIFF_W + 1)'(2 * MARGIN);
    assign diff    = {rval[VAL_W-1], rval} - {lo_reg[VAL_W-1], lo_reg};
    assign num     = height_reg * diff[DIFF_W-1:0];
    assign trial   = {rem_reg, low_reg[Q_W-1]};
    assign qbit    = (trial >= {1'b0, den_reg});
    assign q_ceil  = {1'b0, q_reg} + ROW_W'(rem_reg != '0);
    assign y       = ROW_W'(origin_y_reg) + ROW_W'(height_reg) - q_ceil;

    always_comb
    begin
        top    = y;
        bottom = y;
        if (idx_reg != '0)
        begin
            if (y < prev_reg)
            begin
                bottom = prev_reg - 1'b1;
            end
            else if (y > prev_reg)
            begin
                top = prev_reg + 1'b1;
            end
        end
    end

    assign status.first_sample = (count_reg == '0);
    assign status.scan_done    = (idx_reg == n_reg);
    assign status.div_done     = (step_reg == DIV_STEPS);
    assign status.last         = ({1'b0, idx_reg} + 1'b1) == {1'b0, n_reg};
    assign status.out_free     = !out_valid_reg || spans.ready;

    assign spans.valid       = out_valid_reg;
    assign spans.column_x    = column_reg;
    assign spans.span_top    = top_reg;
    assign spans.span_bottom = bottom_reg;
    assign spans.last_column = last_reg;

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            height_reg    <= H_RESET;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                case (reg_index)
                    REG_ORIGIN_X:    origin_x_reg <= write_data[OX_W-1:0];
                    REG_ORIGIN_Y:    origin_y_reg <= write_data[OY_W-1:0];
                    REG_PLOT_HEIGHT: height_reg   <= write_data[H_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.push)
            begin
                head_reg  <= head_dec;
                count_reg <= (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (spans.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            n_reg   <= count_reg;
            idx_reg <= CNT_W'(1);
            ptr_reg <= (head_dec == LAST_PTR) ? '0 : head_dec + 1'b1;
            hi_reg  <= sample_ext;
            lo_reg  <= sample_ext;
        end
        if (cmd.scan_upd)
        begin
            if (rval > hi_reg)
            begin
                hi_reg <= rval;
            end
            if (rval < lo_reg)
            begin
                lo_reg <= rval;
            end
            idx_reg <= idx_reg + 1'b1;
            ptr_reg <= ptr_inc;
        end
        if (cmd.start_draw)
        begin
            den_reg <= den_sum[DIFF_W-1:0];
            lo_reg  <= lo_reg - MARGIN;
            idx_reg <= '0;
            ptr_reg <= head_reg;
        end
        if (cmd.div_load)
        begin
            rem_reg  <= num[NUM_W-1:Q_W];
            low_reg  <= num[Q_W-1:0];
            q_reg    <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= qbit ? DIFF_W'(trial - {1'b0, den_reg}) : trial[DIFF_W-1:0];
            low_reg  <= {low_reg[Q_W-2:0], 1'b0};
            q_reg    <= {q_reg[Q_W-2:0], qbit};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            column_reg <= COL_W'(origin_x_reg) + COL_BASE - COL_W'(idx_reg);
            top_reg    <= COL_W'(top);
            bottom_reg <= COL_W'(bottom);
            last_reg   <= status.last;
            prev_reg   <= y;
            idx_reg    <= idx_reg + 1'b1;
            ptr_reg    <= ptr_inc;
        end
    end
endmodule

// File: sv/autoscaled_scrolling_graph.sv
// ----------------------------------------------------------------------------
// autoscaled_scrolling_graph
// pushes a temperature sample into a history and draws the autoscaled
// window as one vertical span per column
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  samples   in   temperature                                      valid/ready
//  spans     out  column_x, span_top, span_bottom, last_column     valid/ready
//  config    in   reg_index, write_data                            write_enable
//
//  one sample with a window of n entries runs a min/max scan (a read and an update
//  state per entry), then per column a ram read, divider load, a six-step restoring
//  divide and the emit; the next sample is accepted only after the last column;
//  n is at most WIDTH - 1; the history ram has one read port
//  the first sample after reset is stored and yields no span
//  history ram needs no clearing; reset zeroes fill count and origins, height = 32
//  a stalled span holds the sequencer in its emit state
// ----------------------------------------------------------------------------
module autoscaled_scrolling_graph #(
    parameter int WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    asg_in_if.sink                          samples,
    asg_out_if.source                       spans,
    input  logic                            write_enable,
    input  logic [asg_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [asg_pkg::CFG_DATA_W-1:0]  write_data
);
    import asg_pkg::*;

    asg_cmd_t    cmd;
    asg_status_t status;
    logic        in_ready;

    assign samples.ready = in_ready;

    asg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    asg_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .temperature  (samples.temperature),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .spans        (spans)
    );
endmodule

// File: sv/asg_checker.sv
// ----------------------------------------------------------------------------
// asg_checker
// port level checks on sample and span traffic, bound to the top level
// ----------------------------------------------------------------------------
module asg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [asg_pkg::COL_W-1:0] column_x,
    input logic [asg_pkg::COL_W-1:0] span_top,
    input logic [asg_pkg::COL_W-1:0] span_bottom,
    input logic                      last_column
);
    import asg_pkg::*;

    logic             seen_reg;
    logic             prev_last_reg;
    logic [COL_W-1:0] prev_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b1;
            prev_col_reg  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_reg <= 1'b1;
            end
            if (out_valid && out_ready)
            begin
                prev_last_reg <= last_column;
                prev_col_reg  <= column_x;
            end
        end
    end

    // stalled span holds
    a_span_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column_x)
            && $stable(span_top) && $stable(span_bottom) && $stable(last_column))
        else $error("stalled span changed");

    // any sample after the first starts a drawing pass
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg && in_valid && in_ready |=> !in_ready)
        else $error("sample taken while drawing should start");

    // columns step down by one within a sample
    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !prev_last_reg |-> column_x == prev_col_reg - 8'd1)
        else $error("column does not follow previous span");

    // newest entry is a single row
    a_first_span_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && prev_last_reg |-> span_top == span_bottom)
        else $error("first span of a sample covers more than one row");
endmodule

bind autoscaled_scrolling_graph asg_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (spans.valid),
    .out_ready   (spans.ready),
    .column_x    (spans.column_x),
    .span_top    (spans.span_top),
    .span_bottom (spans.span_bottom),
    .last_column (spans.last_column)
);

// File: tb/sv/asg_span_checker.sv
// ----------------------------------------------------------------------------
// asg_span_checker
// watches the sample and span channels and the register port, predicts the
// column spans of every accepted sample and compares them in order
// ----------------------------------------------------------------------------
module asg_span_checker #(
    parameter int WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    asg_in_if                              samples,
    asg_out_if                             spans,
    input  logic                           write_enable,
    input  logic [asg_pkg::CFG_IDX_W-1:0]  reg_index,
    input  logic [asg_pkg::CFG_DATA_W-1:0] write_data,
    output int                             failures,
    output int                             spans_due_count
);
    import asg_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] column_x;
        logic [COL_W-1:0] span_top;
        logic [COL_W-1:0] span_bottom;
        logic             last_column;
    } span_t;

    span_t spans_due[$];
    int    history_vals[WIDTH];
    int    fill_count;
    int    cfg_origin_x;
    int    cfg_origin_y;
    int    cfg_height;

    initial begin
        failures        = 0;
        spans_due_count = 0;
    end

    function automatic int scaled_row(input int v, input int lo, input int hi);
        int num;
        int range;
        int q;
        num   = cfg_height * (v - lo);
        range = hi - lo;
        q     = (num + range - 1) / range;
        return cfg_origin_y + cfg_height - q;
    endfunction

    task automatic predict_spans(input logic signed [TEMP_W-1:0] temperature);
        int    n;
        int    i;
        int    hi;
        int    lo;
        int    y;
        int    prev;
        int    top;
        int    bottom;
        span_t s;
        n    = fill_count;
        prev = 0;
        for (i = WIDTH - 1; i > 0; i--)
        begin
            history_vals[i] = history_vals[i-1];
        end
        history_vals[0] = int'(temperature);
        hi = history_vals[0];
        lo = history_vals[0];
        for (i = 1; i < n; i++)
        begin
            if (history_vals[i] > hi)
            begin
                hi = history_vals[i];
            end
            if (history_vals[i] < lo)
            begin
                lo = history_vals[i];
            end
        end
        hi = hi + 10;
        lo = lo - 10;
        for (i = 0; i < n; i++)
        begin
            y      = scaled_row(history_vals[i], lo, hi);
            top    = y;
            bottom = y;
            // span reaches toward the previous row, stopping one short
            if (i != 0)
            begin
                if (y < prev)
                begin
                    bottom = prev - 1;
                end
                else if (y > prev)
                begin
                    top = prev + 1;
                end
            end
            s.column_x    = COL_W'(cfg_origin_x + WIDTH - i);
            s.span_top    = COL_W'(top);
            s.span_bottom = COL_W'(bottom);
            s.last_column = (i + 1 == n);
            spans_due.push_back(s);
            prev = y;
        end
        if (n < WIDTH - 1)
        begin
            fill_count = n + 1;
        end
        spans_due_count = spans_due_count + n;
    endtask

    task automatic flag_span(input string why, input span_t want, input span_t got);
        if (failures < 10)
        begin
            $display("%s: expected x=%0d top=%0d bottom=%0d last=%0b", why,
                     want.column_x, want.span_top, want.span_bottom, want.last_column);
            $display("    got x=%0d top=%0d bottom=%0d last=%0b",
                     got.column_x, got.span_top, got.span_bottom, got.last_column);
        end
        failures = failures + 1;
    endtask

    always @(posedge clk)
    begin
        span_t got;
        span_t want;
        if (!rst_n)
        begin
            spans_due.delete();
            spans_due_count = 0;
            fill_count      = 0;
            cfg_origin_x    = 0;
            cfg_origin_y    = 0;
            cfg_height      = int'(H_RESET);
        end
        else
        begin
            if (write_enable)
            begin
                case (reg_index)
                    REG_ORIGIN_X:    cfg_origin_x = int'(write_data[OX_W-1:0]);
                    REG_ORIGIN_Y:    cfg_origin_y = int'(write_data[OY_W-1:0]);
                    REG_PLOT_HEIGHT: cfg_height   = int'(write_data[H_W-1:0]);
                    default:         ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                predict_spans(samples.temperature);
            end
            if (spans.valid && spans.ready)
            begin
                got.column_x    = spans.column_x;
                got.span_top    = spans.span_top;
                got.span_bottom = spans.span_bottom;
                got.last_column = spans.last_column;
                if (spans_due.size() == 0)
                begin
                    flag_span("unexpected span", '0, got);
                end
                else
                begin
                    want            = spans_due.pop_front();
                    spans_due_count = spans_due_count - 1;
                    if (got !== want)
                    begin
                        flag_span("span mismatch", want, got);
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/autoscaled_scrolling_graph_tb.sv
// ----------------------------------------------------------------------------
// autoscaled_scrolling_graph_tb
// drives temperature samples and register writes into the graph block with
// random gaps and back-pressure; the span checker predicts and compares
// ----------------------------------------------------------------------------
module autoscaled_scrolling_graph_tb;
    import asg_pkg::*;

    localparam int WIDTH        = 64;
    localparam int JITTER_MAX   = 16;
    localparam int DRAIN_CYCLES = 1000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 25;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]  reg_index    = '0;
    logic [CFG_DATA_W-1:0] write_data   = '0;

    int failures;
    int spans_due_count;
    int holds_asked = 0;
    int holds_done  = 0;
    int idle_cycles = 0;
    int walk_temp   = 2000;
    bit calm_sender = 1'b0;

    asg_in_if  samples_if ();
    asg_out_if spans_if ();

    autoscaled_scrolling_graph #(.WIDTH(WIDTH)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples_if),
        .spans        (spans_if),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    asg_span_checker #(.WIDTH(WIDTH)) span_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (samples_if),
        .spans           (spans_if),
        .write_enable    (write_enable),
        .reg_index       (reg_index),
        .write_data      (write_data),
        .failures        (failures),
        .spans_due_count (spans_due_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || write_enable || (samples_if.valid && samples_if.ready)
            || (spans_if.valid && spans_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [TEMP_W-1:0] next_temperature();
        int pick;
        int t;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            t = walk_temp + int'($urandom_range(0, 400)) - 200;
            if (t < -4000)
            begin
                t = -4000;
            end
            if (t > 12500)
            begin
                t = 12500;
            end
            walk_temp = t;
        end
        else if (pick < 9)
        begin
            t = int'($urandom_range(0, 16500)) - 4000;
        end
        else
        begin
            t = int'($urandom_range(0, 32767)) - 16384;
        end
        return TEMP_W'(t);
    endfunction

    task automatic send_sample(input logic signed [TEMP_W-1:0] t);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, JITTER_MAX);
        if (gap > 0)
        begin
            samples_if.valid       <= 1'b0;
            samples_if.temperature <= TEMP_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        samples_if.valid       <= 1'b1;
        samples_if.temperature <= t;
        do @(posedge clk); while (!samples_if.ready);
        @(negedge clk);
    endtask

    task automatic drain_spans();
        samples_if.valid <= 1'b0;
        do @(negedge clk); while (spans_due_count != 0);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ox,
                                  input logic [CFG_DATA_W-1:0] oy,
                                  input logic [CFG_DATA_W-1:0] height);
        drain_spans();
        // a sample may still be in flight with no span left to show it
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_enable <= 1'b1;
        reg_index    <= REG_ORIGIN_X;
        write_data   <= ox;
        @(negedge clk);
        reg_index  <= REG_ORIGIN_Y;
        write_data <= oy;
        @(negedge clk);
        reg_index  <= REG_PLOT_HEIGHT;
        write_data <= height;
        @(negedge clk);
        reg_index  <= REG_SPARE;
        write_data <= CFG_DATA_W'($urandom);
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    // span receiver
    initial
    begin
        int gap;
        int calm_left;
        calm_left      = 0;
        spans_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                gap        = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            else if (calm_left > 0)
            begin
                gap       = 0;
                calm_left = calm_left - 1;
            end
            else
            begin
                gap = $urandom_range(0, JITTER_MAX);
                if ($urandom_range(0, 40) == 0)
                begin
                    calm_left = $urandom_range(20, 80);
                end
            end
            if (gap > 0)
            begin
                spans_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            spans_if.ready <= 1'b1;
            do @(posedge clk); while (!spans_if.valid);
            @(negedge clk);
        end
    end

    // sample source and verdict
    initial
    begin
        int opening_temps[11] = '{0, -16384, 16383, -4000, 12500, 2500, 2500, 2500,
                                  0, -1, 12500};
        int flat_temps[4]     = '{16383, -16384, 100, 100};
        int tall_temps[5]     = '{-16384, 16383, -16384, 5000, 5001};
        int phase;
        int k;
        samples_if.valid       = 1'b0;
        samples_if.temperature = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, first sample gives no span
        foreach (opening_temps[k])
        begin
            send_sample(TEMP_W'(opening_temps[k]));
        end
        // zero plot height
        apply_settings(7'd127, 7'h7f, 7'h40);
        foreach (flat_temps[k])
        begin
            send_sample(TEMP_W'(flat_temps[k]));
        end
        apply_settings(7'd0, 7'h40, 7'h7f);
        foreach (tall_temps[k])
        begin
            send_sample(TEMP_W'(tall_temps[k]));
        end

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       apply_settings(7'd127, 7'd63, 7'd63);
                2:       apply_settings(7'd0, 7'd0, 7'd1);
                default: apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                        CFG_DATA_W'($urandom));
            endcase
            calm_sender = (phase == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 1 && k == 10)
                begin
                    holds_asked = holds_asked + 1;
                end
                if (phase == 3 && k == 15)
                begin
                    drain_spans();
                end
                send_sample(next_temperature());
            end
        end

        drain_spans();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && spans_due_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/asg_pkg.sv
sv/asg_in_if.sv
sv/asg_out_if.sv
sv/asg_ram.sv
sv/asg_ctrl.sv
sv/asg_datapath.sv
sv/autoscaled_scrolling_graph.sv
sv/asg_checker.sv
tb/sv/asg_span_checker.sv
tb/sv/autoscaled_scrolling_graph_tb.sv
